>>> design/text_glyph_pixel_expander_defines.svh
// Assertion macros for the glyph pixel expander checkers.
`ifndef TEXT_GLYPH_PIXEL_EXPANDER_DEFINES_SVH
`define TEXT_GLYPH_PIXEL_EXPANDER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TXGP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("txgp check failed");

// Consequent checked in the cycle after the antecedent.
`define TXGP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("txgp check failed");

`endif

>>> design/txgp_pkg.sv
package txgp_pkg;

    localparam int GLYPH_COUNT = 128;
    localparam int CELL_WIDTH  = 8;
    localparam int CELL_HEIGHT = 8;

    localparam int GLYPH_ROWS  = 8;
    localparam int GLYPH_BITS  = 8;
    localparam int GLYPH_PIX   = GLYPH_ROWS * GLYPH_BITS;
    localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
    localparam int GIDX_W      = $clog2(GLYPH_COUNT);
    localparam int FONT_AW     = $clog2(FONT_DEPTH);
    localparam int COORD_W     = 11;
    localparam int CURSOR_W    = 7;

    localparam logic [CURSOR_W-1:0] CURSOR_MAX = 7'd127;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] PRINT_LO     = 8'h20;
    localparam logic [7:0] PRINT_HI     = 8'h7E;

    localparam logic CMD_FONT_WRITE = 1'b0;
    localparam logic CMD_DRAW       = 1'b1;

    typedef struct packed {
        logic clr_en;
        logic in_ready;
        logic load_en;
        logic scan_en;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_done;
        logic in_print;
        logic load_done;
        logic scan_done;
    } t_dp_status;

    function automatic logic [CURSOR_W-1:0] sat_inc(input logic [CURSOR_W-1:0] v);
        return (v == CURSOR_MAX) ? v : v + 1'b1;
    endfunction

endpackage

>>> design/txgp_ctrl.sv
module txgp_ctrl
    import txgp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_sts,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_done) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid && i_sts.in_print) n_state = S_LOAD;
            S_LOAD:  if (i_sts.load_done) n_state = S_SCAN;
            S_SCAN:  if (i_sts.scan_done) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.clr_en   = (r_state == S_CLEAR);
    assign o_cmd.in_ready = (r_state == S_IDLE);
    assign o_cmd.load_en  = (r_state == S_LOAD);
    assign o_cmd.scan_en  = (r_state == S_SCAN);

endmodule

>>> design/txgp_dp.sv
module txgp_dp
    import txgp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl_cmd          i_cmd,
    output t_dp_status         o_sts,
    input  logic               i_in_valid,
    input  logic               i_command,
    input  logic [7:0]         i_char_code,
    input  logic [2:0]         i_glyph_row,
    input  logic [7:0]         i_row_bits,
    input  logic               i_first_of_string,
    input  logic [9:0]         i_origin_x,
    input  logic [9:0]         i_origin_y,
    input  logic [7:0]         i_fore_color,
    input  logic [7:0]         i_back_color,
    input  logic               i_cfg_valid,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [COORD_W-1:0] o_pixel_x,
    output logic [COORD_W-1:0] o_pixel_y,
    output logic [7:0]         o_pixel_color,
    output logic               o_last_pixel
);

    logic [7:0] r_font [FONT_DEPTH];
    logic [7:0] r_rd_data;

    logic [FONT_AW-1:0]  r_clr_addr;
    logic [CURSOR_W-1:0] r_col;
    logic [CURSOR_W-1:0] r_line;
    logic [7:0]          r_tc;
    logic                r_out_valid;
    logic [5:0]          r_pos;
    logic [3:0]          r_row_cnt;

    logic [GIDX_W-1:0]    r_glyph_idx;
    logic                 r_oob;
    logic [7:0]           r_fg;
    logic [7:0]           r_bg;
    logic [9:0]           r_ox;
    logic [9:0]           r_oy;
    logic [COORD_W-1:0]   r_base_x;
    logic [COORD_W-1:0]   r_base_y;
    logic [GLYPH_PIX-1:0] r_glyph_bits;
    logic [COORD_W-1:0]   r_px;
    logic [COORD_W-1:0]   r_py;
    logic [7:0]           r_pc;
    logic                 r_last;

    logic                 accept;
    logic                 is_draw;
    logic                 in_range;
    logic                 font_wr;
    logic [FONT_AW-1:0]   wr_addr;
    logic [FONT_AW-1:0]   rd_addr;
    logic [CURSOR_W-1:0]  col_eff;
    logic [CURSOR_W-1:0]  line_eff;
    logic [2:0]           cap_row;
    logic [7:0]           cap_data;
    logic                 fg_vis;
    logic                 bg_vis;
    logic [GLYPH_PIX-1:0] vis;
    logic [GLYPH_PIX-1:0] later;
    logic                 scan_step;

    assign accept   = i_in_valid && i_cmd.in_ready;
    assign is_draw  = (i_command == CMD_DRAW);
    assign in_range = ({24'd0, i_char_code} < 32'(GLYPH_COUNT));
    assign font_wr  = accept && !is_draw && in_range;
    assign wr_addr  = {i_char_code[GIDX_W-1:0], i_glyph_row};
    assign rd_addr  = {r_glyph_idx, r_row_cnt[2:0]};
    assign col_eff  = i_first_of_string ? '0 : r_col;
    assign line_eff = i_first_of_string ? '0 : r_line;
    assign cap_row  = 3'(r_row_cnt - 4'd1);
    assign cap_data = r_oob ? 8'd0 : r_rd_data;
    assign fg_vis   = (r_fg != r_tc);
    assign bg_vis   = (r_bg != r_tc);
    assign scan_step = i_cmd.scan_en && (!r_out_valid || i_out_ready);

    always_comb begin
        for (int p = 0; p < GLYPH_PIX; p++) begin
            vis[p]   = r_glyph_bits[p] ? fg_vis : bg_vis;
            later[p] = (6'(p) > r_pos);
        end
    end

    assign o_sts.clr_done  = i_cmd.clr_en && (r_clr_addr == FONT_AW'(FONT_DEPTH - 1));
    assign o_sts.in_print  = is_draw && (i_char_code >= PRINT_LO) && (i_char_code <= PRINT_HI);
    assign o_sts.load_done = i_cmd.load_en && (r_row_cnt == 4'(GLYPH_ROWS));
    assign o_sts.scan_done = scan_step && (r_pos == 6'(GLYPH_PIX - 1));

    // font store: clearing pass, font writes, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_font[r_clr_addr] <= 8'd0;
        end else if (font_wr) begin
            r_font[wr_addr] <= i_row_bits;
        end
        r_rd_data <= r_font[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_col       <= '0;
            r_line      <= '0;
            r_tc        <= 8'd0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_row_cnt   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_tc <= i_cfg_data;
            end
            if (i_cmd.clr_en) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (accept && is_draw) begin
                if (i_char_code == NEWLINE_CODE) begin
                    r_col  <= '0;
                    r_line <= sat_inc(line_eff);
                end else begin
                    r_col  <= col_eff;
                    r_line <= line_eff;
                end
            end else if (o_sts.scan_done) begin
                r_col <= sat_inc(r_col);
            end
            if (accept) begin
                r_row_cnt <= '0;
                r_pos     <= '0;
            end else begin
                if (i_cmd.load_en) begin
                    r_row_cnt <= r_row_cnt + 1'b1;
                end
                if (scan_step) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (scan_step) begin
                r_out_valid <= vis[r_pos];
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_glyph_idx <= i_char_code[GIDX_W-1:0];
            r_oob       <= !in_range;
            r_fg        <= i_fore_color;
            r_bg        <= i_back_color;
            r_ox        <= i_origin_x;
            r_oy        <= i_origin_y;
        end
        if (i_cmd.load_en) begin
            r_base_x <= COORD_W'(r_ox) + COORD_W'({4'd0, r_col} * COORD_W'(CELL_WIDTH));
            r_base_y <= COORD_W'(r_oy) + COORD_W'({4'd0, r_line} * COORD_W'(CELL_HEIGHT));
            if (r_row_cnt != 4'd0) begin
                for (int b = 0; b < GLYPH_BITS; b++) begin
                    r_glyph_bits[{cap_row, 3'(b)}] <= cap_data[3'(GLYPH_BITS - 1 - b)];
                end
            end
        end
        if (scan_step) begin
            r_px   <= r_base_x + {8'd0, r_pos[2:0]};
            r_py   <= r_base_y + {8'd0, r_pos[5:3]};
            r_pc   <= r_glyph_bits[r_pos] ? r_fg : r_bg;
            r_last <= ~|(vis & later);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pc;
    assign o_last_pixel  = r_last;

endmodule

>>> design/text_glyph_pixel_expander.sv
// Text glyph pixel expander: 8x8 bitmap font character generator.
// Input channel (i_in_valid / o_in_ready): one command per transfer. A font
// write stores one glyph row; codes beyond the 128-glyph store are dropped.
// A draw of a newline or a non-printable code updates the cursors. A
// printable draw is accepted, then reads the eight glyph rows from the font
// memory through its registered read port and scans the 64 pixels, one per
// cycle unless the output stalls; o_in_ready stays low meanwhile.
// Output channel (o_out_valid / i_out_ready): one pixel write per transfer,
// taken from an output register; o_last_pixel marks the final pixel of a
// character. Transparent pixels are skipped and leave a bubble. A stall on
// the output halts the pixel scan; the next command is accepted as soon as
// the scan has handed its last pixel to the output register.
// Configuration channel (i_cfg_valid / o_cfg_ready): always ready, writes
// the transparent color.
// Reset (i_rst_n, synchronous, active low) clears the cursors and the
// transparent color, then a clearing pass zeroes the 1024-row font store
// with o_in_ready low.
module text_glyph_pixel_expander
    import txgp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic [7:0]         i_char_code,
    input  logic [2:0]         i_glyph_row,
    input  logic [7:0]         i_row_bits,
    input  logic               i_first_of_string,
    input  logic [9:0]         i_origin_x,
    input  logic [9:0]         i_origin_y,
    input  logic [7:0]         i_fore_color,
    input  logic [7:0]         i_back_color,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COORD_W-1:0] o_pixel_x,
    output logic [COORD_W-1:0] o_pixel_y,
    output logic [7:0]         o_pixel_color,
    output logic               o_last_pixel,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status sts;

    txgp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    txgp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_in_valid        (i_in_valid),
        .i_command         (i_command),
        .i_char_code       (i_char_code),
        .i_glyph_row       (i_glyph_row),
        .i_row_bits        (i_row_bits),
        .i_first_of_string (i_first_of_string),
        .i_origin_x        (i_origin_x),
        .i_origin_y        (i_origin_y),
        .i_fore_color      (i_fore_color),
        .i_back_color      (i_back_color),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_pixel_x         (o_pixel_x),
        .o_pixel_y         (o_pixel_y),
        .o_pixel_color     (o_pixel_color),
        .o_last_pixel      (o_last_pixel)
    );

    assign o_in_ready  = cmd.in_ready;
    assign o_cfg_ready = 1'b1;

endmodule

>>> design/txgp_chk.sv
`include "text_glyph_pixel_expander_defines.svh"

module txgp_chk
    import txgp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_command,
    input logic [7:0]         i_char_code,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [COORD_W-1:0] o_pixel_x,
    input logic [COORD_W-1:0] o_pixel_y,
    input logic [7:0]         o_pixel_color,
    input logic               o_last_pixel
);

    logic                 in_xfer;
    logic                 print_code;
    logic [2*COORD_W+8:0] out_word;

    assign in_xfer    = i_in_valid && o_in_ready;
    assign print_code = (i_char_code >= PRINT_LO) && (i_char_code <= PRINT_HI);
    assign out_word   = {o_pixel_x, o_pixel_y, o_pixel_color, o_last_pixel};

    `TXGP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `TXGP_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(out_word))
    `TXGP_ASSERT_NEXT(a_draw_busy, in_xfer && (i_command == CMD_DRAW) && print_code, !o_in_ready)
    `TXGP_ASSERT_NEXT(a_font_wr_free, in_xfer && (i_command == CMD_FONT_WRITE), o_in_ready)

endmodule

bind text_glyph_pixel_expander txgp_chk u_txgp_chk (.*);

>>> sim/text_glyph_pixel_expander_test.sv
module text_glyph_pixel_expander_test
    import txgp_pkg::*;
();

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_HOLD     = 400;

    typedef struct packed {
        logic       command;
        logic [7:0] code;
        logic [2:0] grow;
        logic [7:0] bits;
        logic       first;
        logic [9:0] ox;
        logic [9:0] oy;
        logic [7:0] fg;
        logic [7:0] bg;
        logic [3:0] gap;
        logic       drain;
    } t_glyph_cmd;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [7:0]         color;
        logic               last;
    } t_pixel;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_command = 1'b0;
    logic [7:0]         i_char_code = '0;
    logic [2:0]         i_glyph_row = '0;
    logic [7:0]         i_row_bits = '0;
    logic               i_first_of_string = 1'b0;
    logic [9:0]         i_origin_x = '0;
    logic [9:0]         i_origin_y = '0;
    logic [7:0]         i_fore_color = '0;
    logic [7:0]         i_back_color = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [COORD_W-1:0] o_pixel_x;
    logic [COORD_W-1:0] o_pixel_y;
    logic [7:0]         o_pixel_color;
    logic               o_last_pixel;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_data = '0;

    text_glyph_pixel_expander uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (i_command),
        .i_char_code       (i_char_code),
        .i_glyph_row       (i_glyph_row),
        .i_row_bits        (i_row_bits),
        .i_first_of_string (i_first_of_string),
        .i_origin_x        (i_origin_x),
        .i_origin_y        (i_origin_y),
        .i_fore_color      (i_fore_color),
        .i_back_color      (i_back_color),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_pixel_x         (o_pixel_x),
        .o_pixel_y         (o_pixel_y),
        .o_pixel_color     (o_pixel_color),
        .o_last_pixel      (o_last_pixel),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // glyph model state
    logic [7:0]          font_rows [FONT_DEPTH];
    logic [CURSOR_W-1:0] col_cur;
    logic [CURSOR_W-1:0] line_cur;
    logic [7:0]          transp_color;

    t_glyph_cmd cmd_queue [$];
    t_pixel     expected_px [$];

    int fails = 0;
    int cmds_done = 0;
    int pixels_seen = 0;
    int cfg_writes = 0;
    int cycle_count = 0;
    int tx_gap_max = 14;
    int rx_stall_max = 14;

    function automatic logic [CURSOR_W-1:0] cursor_bump(input logic [CURSOR_W-1:0] c);
        if (c >= CURSOR_MAX)
            return CURSOR_MAX;
        return c + 1'b1;
    endfunction

    // Applies one accepted command to the glyph model, queueing its pixels.
    task automatic absorb_cmd(input t_glyph_cmd it);
        logic [7:0] rbits;
        logic [7:0] color;
        t_pixel     px;
        int         base_x;
        int         base_y;
        int         last_idx;
        if (it.command == CMD_FONT_WRITE) begin
            if (it.code < GLYPH_COUNT)
                font_rows[it.code * GLYPH_ROWS + it.grow] = it.bits;
            return;
        end
        if (it.first) begin
            col_cur = '0;
            line_cur = '0;
        end
        if (it.code == NEWLINE_CODE) begin
            col_cur = '0;
            line_cur = cursor_bump(line_cur);
            return;
        end
        if (it.code < PRINT_LO || it.code > PRINT_HI)
            return;
        base_x = it.ox + col_cur * CELL_WIDTH;
        base_y = it.oy + line_cur * CELL_HEIGHT;
        last_idx = -1;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            rbits = font_rows[it.code * GLYPH_ROWS + r];
            for (int b = 0; b < GLYPH_BITS; b++) begin
                color = rbits[7-b] ? it.fg : it.bg;
                if (color != transp_color)
                    last_idx = r * GLYPH_BITS + b;
            end
        end
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            rbits = font_rows[it.code * GLYPH_ROWS + r];
            for (int b = 0; b < GLYPH_BITS; b++) begin
                color = rbits[7-b] ? it.fg : it.bg;
                if (color != transp_color) begin
                    px.x = COORD_W'(base_x + b);
                    px.y = COORD_W'(base_y + r);
                    px.color = color;
                    px.last = (r * GLYPH_BITS + b) == last_idx;
                    expected_px.push_back(px);
                end
            end
        end
        col_cur = cursor_bump(col_cur);
    endtask

    function automatic t_glyph_cmd mk_font_row(input logic [7:0] code, input logic [2:0] row,
                                               input logic [7:0] bits);
        t_glyph_cmd it;
        it = '0;
        it.command = CMD_FONT_WRITE;
        it.code = code;
        it.grow = row;
        it.bits = bits;
        it.ox = 10'($urandom);
        it.oy = 10'($urandom);
        return it;
    endfunction

    function automatic t_glyph_cmd mk_draw(input logic [7:0] code, input logic first,
                                           input logic [9:0] ox, input logic [9:0] oy,
                                           input logic [7:0] fg, input logic [7:0] bg);
        t_glyph_cmd it;
        it = '0;
        it.command = CMD_DRAW;
        it.code = code;
        it.grow = 3'($urandom);
        it.bits = 8'($urandom);
        it.first = first;
        it.ox = ox;
        it.oy = oy;
        it.fg = fg;
        it.bg = bg;
        return it;
    endfunction

    task automatic enqueue(input t_glyph_cmd it, input logic drain);
        it.gap = 4'($urandom_range(0, tx_gap_max));
        it.drain = drain;
        cmd_queue.push_back(it);
    endtask

    // Input driver
    t_glyph_cmd staged_cmd;
    t_glyph_cmd offered_cmd;
    logic       staged = 1'b0;
    int         gap_left = 0;

    always @(posedge i_clk) begin : drive_proc
        logic offer;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offer = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                absorb_cmd(offered_cmd);
                cmds_done++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (!staged && cmd_queue.size() > 0) begin
                    staged_cmd = cmd_queue.pop_front();
                    staged = 1'b1;
                    gap_left = int'(staged_cmd.gap);
                end
                if (staged) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else if (!staged_cmd.drain || expected_px.size() == 0) begin
                        offered_cmd = staged_cmd;
                        staged = 1'b0;
                        offer = 1'b1;
                        i_command <= staged_cmd.command;
                        i_char_code <= staged_cmd.code;
                        i_glyph_row <= staged_cmd.grow;
                        i_row_bits <= staged_cmd.bits;
                        i_first_of_string <= staged_cmd.first;
                        i_origin_x <= staged_cmd.ox;
                        i_origin_y <= staged_cmd.oy;
                        i_fore_color <= staged_cmd.fg;
                        i_back_color <= staged_cmd.bg;
                    end
                end
            end
            i_in_valid <= offer;
        end
    end

    // Long receiver holds, started as the pixel count grows
    int hold_left = 0;
    int holds_done = 0;

    always @(posedge i_clk) begin : hold_proc
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if ((holds_done == 0 && pixels_seen >= 200) ||
                     (holds_done == 1 && pixels_seen >= 2500)) begin
            hold_left <= LONG_HOLD;
            holds_done <= holds_done + 1;
        end
    end

    // Pixel monitor
    int stall_left = 0;

    always @(posedge i_clk) begin : check_proc
        t_pixel want;
        logic   ready_next;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_px.size() == 0) begin
                    $error("unexpected pixel transfer: x=%0d y=%0d color=%0d last=%0d",
                           o_pixel_x, o_pixel_y, o_pixel_color, o_last_pixel);
                    fails++;
                end else begin
                    want = expected_px.pop_front();
                    if (o_pixel_x !== want.x) begin
                        $error("pixel_x: expected %0d, got %0d", want.x, o_pixel_x);
                        fails++;
                    end
                    if (o_pixel_y !== want.y) begin
                        $error("pixel_y: expected %0d, got %0d", want.y, o_pixel_y);
                        fails++;
                    end
                    if (o_pixel_color !== want.color) begin
                        $error("pixel_color: expected %0d, got %0d", want.color, o_pixel_color);
                        fails++;
                    end
                    if (o_last_pixel !== want.last) begin
                        $error("last_pixel: expected %0d, got %0d", want.last, o_last_pixel);
                        fails++;
                    end
                end
                pixels_seen++;
                stall_left = $urandom_range(0, rx_stall_max);
            end
            if (hold_left > 0) begin
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            i_out_ready <= ready_next;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycle_count, expected_px.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_quiet();
        while (cmd_queue.size() != 0 || staged || i_in_valid || expected_px.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_transparent(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        transp_color = value;
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // Mix of glyph loads, short strings and noise.
    task automatic build_random(input int count);
        int         made;
        int         pick;
        int         len;
        logic [7:0] code;
        logic [9:0] ox;
        logic [9:0] oy;
        logic [7:0] fg;
        logic [7:0] bg;
        t_glyph_cmd it;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                code = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(128, 255))
                                                    : 8'($urandom_range(PRINT_LO, PRINT_HI));
                for (int r = 0; r < GLYPH_ROWS; r++)
                    enqueue(mk_font_row(code, 3'(r), 8'($urandom)), 1'b0);
                made += GLYPH_ROWS;
            end else if (pick < 8) begin
                len = $urandom_range(1, 8);
                ox = 10'($urandom);
                oy = 10'($urandom);
                fg = 8'($urandom);
                bg = $urandom_range(0, 1) ? transp_color : 8'($urandom);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 14)
                        code = 8'($urandom_range(PRINT_LO, PRINT_HI));
                    else if (pick < 17)
                        code = NEWLINE_CODE;
                    else
                        code = 8'($urandom);
                    enqueue(mk_draw(code, i == 0, ox, oy, fg, bg),
                            i == 0 && $urandom_range(0, 7) == 0);
                end
                made += len;
            end else begin
                it = mk_draw(8'($urandom), 1'($urandom), 10'($urandom), 10'($urandom),
                             8'($urandom), 8'($urandom));
                it.command = 1'($urandom);
                enqueue(it, 1'b0);
                made++;
            end
        end
    endtask

    // One string that drives both cursors into saturation.
    task automatic build_long_string();
        logic [9:0] ox;
        logic [9:0] oy;
        logic       visible;
        ox = 10'($urandom);
        oy = 10'($urandom);
        enqueue(mk_draw(8'h41, 1'b1, ox, oy, 8'($urandom), 8'($urandom)), 1'b1);
        for (int i = 0; i < 129; i++)
            enqueue(mk_draw(NEWLINE_CODE, 1'b0, ox, oy, 8'($urandom), 8'($urandom)), 1'b0);
        for (int i = 0; i < 130; i++) begin
            visible = (i % 4 == 0) || (i >= 125);
            if (visible)
                enqueue(mk_draw(8'($urandom_range(PRINT_LO, PRINT_HI)), 1'b0, ox, oy,
                                8'($urandom), 8'($urandom)), 1'b0);
            else
                enqueue(mk_draw(8'($urandom_range(PRINT_LO, PRINT_HI)), 1'b0, ox, oy,
                                transp_color, transp_color), 1'b0);
        end
    endtask

    initial begin
        t_glyph_cmd it;
        foreach (font_rows[i])
            font_rows[i] = '0;
        col_cur = '0;
        line_cur = '0;
        transp_color = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: transparent color at its reset value of zero.
        enqueue(mk_font_row(8'h41, 3'd0, 8'h80), 1'b0);
        enqueue(mk_font_row(8'h41, 3'd1, 8'h01), 1'b0);
        enqueue(mk_font_row(8'h41, 3'd2, 8'hFF), 1'b0);
        enqueue(mk_font_row(8'h41, 3'd3, 8'h00), 1'b0);
        enqueue(mk_font_row(8'h41, 3'd4, 8'hAA), 1'b0);
        enqueue(mk_font_row(8'h41, 3'd5, 8'h55), 1'b0);
        enqueue(mk_font_row(8'h41, 3'd6, 8'h3C), 1'b0);
        enqueue(mk_font_row(8'h41, 3'd7, 8'hC3), 1'b0);
        // index beyond the store must not alias onto 'A'
        enqueue(mk_font_row(8'hC1, 3'd3, 8'hFF), 1'b0);
        enqueue(mk_draw(8'h41, 1'b1, 10'h3FF, 10'h3FF, 8'hFF, 8'h00), 1'b0);
        enqueue(mk_draw(8'h41, 1'b0, 10'h3FF, 10'h3FF, 8'h00, 8'hFF), 1'b0);
        // blank glyph with transparent background: nothing drawn, cursor moves
        enqueue(mk_draw(8'h20, 1'b0, 10'h3FF, 10'h3FF, 8'h12, 8'h00), 1'b0);
        enqueue(mk_draw(8'h7E, 1'b0, 10'h3FF, 10'h3FF, 8'h00, 8'h5A), 1'b0);
        enqueue(mk_draw(NEWLINE_CODE, 1'b0, 10'h3FF, 10'h3FF, 8'hFF, 8'hFF), 1'b0);
        enqueue(mk_draw(8'h00, 1'b0, 10'h3FF, 10'h3FF, 8'hFF, 8'hFF), 1'b0);
        enqueue(mk_draw(8'h1F, 1'b0, 10'h3FF, 10'h3FF, 8'hFF, 8'hFF), 1'b0);
        enqueue(mk_draw(8'h7F, 1'b0, 10'h3FF, 10'h3FF, 8'hFF, 8'hFF), 1'b0);
        enqueue(mk_draw(8'hFF, 1'b0, 10'h3FF, 10'h3FF, 8'hFF, 8'hFF), 1'b0);
        enqueue(mk_draw(8'h41, 1'b0, 10'h3FF, 10'h3FF, 8'h77, 8'h77), 1'b0);
        enqueue(mk_draw(8'h41, 1'b1, 10'h000, 10'h000, 8'h01, 8'h80), 1'b0);
        // font write carrying first_of_string leaves the cursors alone
        it = mk_font_row(8'h41, 3'd7, 8'h00);
        it.first = 1'b1;
        enqueue(it, 1'b0);
        enqueue(mk_draw(8'h41, 1'b0, 10'h000, 10'h000, 8'hFF, 8'h00), 1'b0);
        enqueue(mk_draw(8'h20, 1'b1, 10'h155, 10'h2AA, 8'h00, 8'hC3), 1'b1);
        wait_quiet();

        write_transparent(8'hFF);
        build_random(70);
        wait_quiet();

        write_transparent(8'h00);
        tx_gap_max = 0;
        rx_stall_max = 0;
        build_random(50);
        build_long_string();
        wait_quiet();

        write_transparent(8'($urandom_range(1, 254)));
        tx_gap_max = 14;
        rx_stall_max = 14;
        build_random(60);
        wait_quiet();

        $display("%0d commands transferred, %0d pixels checked, %0d transparent color writes",
                 cmds_done, pixels_seen, cfg_writes);
        $display("covered font loads, strings, newlines, ignored codes and cursor saturation");
        if (fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
